>>> rtl/core/ttci_pkg.sv
// Shared types and constants for the terminal control sequence interpreter.
// No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package ttci_pkg;

    localparam int SCREEN_SIZE_DEF = 10;

    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 4;
    localparam int PH_W   = 2;

    // item modes
    localparam logic [MODE_W-1:0] MODE_FEED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEW  = 2'd2;

    // escape parser states
    localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PH_W-1:0] PH_ESC  = 2'd1;
    localparam logic [PH_W-1:0] PH_ROW  = 2'd2;

    // characters
    localparam logic [BYTE_W-1:0] CH_CARET   = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CMD_ERASE  = 8'h65; // e
    localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h63; // c
    localparam logic [BYTE_W-1:0] CMD_RIGHT  = 8'h72; // r
    localparam logic [BYTE_W-1:0] CMD_UP     = 8'h75; // u
    localparam logic [BYTE_W-1:0] CMD_DOWN   = 8'h64; // d
    localparam logic [BYTE_W-1:0] CMD_LEFT   = 8'h6C; // l
    localparam logic [BYTE_W-1:0] CMD_BOL    = 8'h62; // b
    localparam logic [BYTE_W-1:0] CMD_HOME   = 8'h68; // h
    localparam logic [BYTE_W-1:0] CMD_INS_ON = 8'h69; // i
    localparam logic [BYTE_W-1:0] CMD_INS_OFF = 8'h6F; // o

    // row operations broadcast to the screen rows
    typedef enum logic [1:0] {
        ROP_NONE,
        ROP_PUT,
        ROP_ERASE,
        ROP_CLEAR
    } t_row_op;

    typedef struct packed {
        t_row_op           op;
        logic [POS_W-1:0]  col;
        logic [BYTE_W-1:0] ch;
        logic              ins;
    } t_row_cmd;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             ins;
        logic [PH_W-1:0]  phase;
    } t_term_state;

endpackage

`default_nettype wire

>>> rtl/core/ttci_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on ttci_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ttci_in_if;
    logic                         valid;
    logic                         ready;
    logic [ttci_pkg::MODE_W-1:0]  mode;
    logic [ttci_pkg::BYTE_W-1:0]  data_byte;
    logic [ttci_pkg::POS_W-1:0]   read_row;
    logic [ttci_pkg::POS_W-1:0]   read_col;

    modport source (output valid, mode, data_byte, read_row, read_col, input ready);
    modport sink   (input valid, mode, data_byte, read_row, read_col, output ready);
endinterface

interface ttci_out_if;
    logic                         valid;
    logic                         ready;
    logic [ttci_pkg::BYTE_W-1:0]  cell_char;
    logic [ttci_pkg::POS_W-1:0]   cursor_row;
    logic [ttci_pkg::POS_W-1:0]   cursor_col;
    logic                         insert_on;
    logic [ttci_pkg::PH_W-1:0]    escape_phase;

    modport source (output valid, cell_char, cursor_row, cursor_col, insert_on, escape_phase,
                    input ready);
    modport sink   (input valid, cell_char, cursor_row, cursor_col, insert_on, escape_phase,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/ttci_row.sv
// One screen row: SCREEN_SIZE character cells with put/insert, erase and clear.
// Depends on ttci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttci_row #(
    parameter int SCREEN_SIZE = ttci_pkg::SCREEN_SIZE_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_en,
    input  wire logic                                       i_sel,
    input  wire ttci_pkg::t_row_cmd                         i_cmd,
    output logic [SCREEN_SIZE-1:0][ttci_pkg::BYTE_W-1:0]    o_cells
);

    localparam int IDX_W = $clog2(SCREEN_SIZE);

    logic [SCREEN_SIZE-1:0][ttci_pkg::BYTE_W-1:0] r_cells;
    logic [SCREEN_SIZE-1:0][ttci_pkg::BYTE_W-1:0] n_cells;

    always_comb begin
        n_cells = r_cells;
        if (i_cmd.op == ttci_pkg::ROP_CLEAR) begin
            for (int j = 0; j < SCREEN_SIZE; j++) begin
                n_cells[j] = ttci_pkg::CH_SPACE;
            end
        end else if (i_sel) begin
            if (i_cmd.op == ttci_pkg::ROP_ERASE) begin
                for (int j = 0; j < SCREEN_SIZE; j++) begin
                    if (ttci_pkg::POS_W'(j) >= i_cmd.col) begin
                        n_cells[j] = ttci_pkg::CH_SPACE;
                    end
                end
            end else if (i_cmd.op == ttci_pkg::ROP_PUT) begin
                // insert: cells right of the cursor move one place, last one drops
                if (i_cmd.ins) begin
                    for (int j = 1; j < SCREEN_SIZE; j++) begin
                        if (ttci_pkg::POS_W'(j) > i_cmd.col) begin
                            n_cells[j] = r_cells[j-1];
                        end
                    end
                end
                n_cells[i_cmd.col[IDX_W-1:0]] = i_cmd.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SCREEN_SIZE; j++) begin
                r_cells[j] <= ttci_pkg::CH_SPACE;
            end
        end else if (i_en) begin
            r_cells <= n_cells;
        end
    end

    assign o_cells = r_cells;

endmodule

`default_nettype wire

>>> rtl/core/ttci_ctrl.sv
// Escape parser and cursor logic: next terminal state and the row command.
// Depends on ttci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttci_ctrl #(
    parameter int SCREEN_SIZE = ttci_pkg::SCREEN_SIZE_DEF
) (
    input  wire logic [ttci_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [ttci_pkg::BYTE_W-1:0]  i_byte,
    input  wire ttci_pkg::t_term_state        i_cur,
    output ttci_pkg::t_term_state             o_next,
    output ttci_pkg::t_row_cmd                o_cmd
);

    localparam logic [ttci_pkg::POS_W-1:0] LAST = ttci_pkg::POS_W'(SCREEN_SIZE - 1);
    localparam logic [ttci_pkg::POS_W-1:0] SIZE = ttci_pkg::POS_W'(SCREEN_SIZE);

    logic                        w_is_digit;
    logic [ttci_pkg::POS_W-1:0]  w_digit;
    logic [ttci_pkg::POS_W-1:0]  w_col_inc;
    logic [ttci_pkg::POS_W-1:0]  w_row_inc;

    always_comb begin
        w_is_digit = (i_byte >= ttci_pkg::CH_ZERO) && (i_byte <= ttci_pkg::CH_NINE);
        // '0'..'9' carry the digit in the low nibble; saturate to the last cell
        w_digit    = (i_byte[3:0] >= SIZE) ? LAST : i_byte[3:0];
        w_col_inc  = (i_cur.col == LAST) ? LAST : i_cur.col + 1'b1;
        w_row_inc  = (i_cur.row == LAST) ? LAST : i_cur.row + 1'b1;
    end

    always_comb begin
        o_next     = i_cur;
        o_cmd.op   = ttci_pkg::ROP_NONE;
        o_cmd.col  = i_cur.col;
        o_cmd.ch   = i_byte;
        o_cmd.ins  = i_cur.ins;

        unique case (i_mode)
            ttci_pkg::MODE_FEED: begin
                priority if (i_cur.phase == ttci_pkg::PH_IDLE) begin
                    if (i_byte == ttci_pkg::CH_CARET) begin
                        o_next.phase = ttci_pkg::PH_ESC;
                    end else if (i_byte != ttci_pkg::CH_NEWLINE) begin
                        o_cmd.op   = ttci_pkg::ROP_PUT;
                        o_next.col = w_col_inc;
                    end
                end else if (i_cur.phase == ttci_pkg::PH_ESC) begin
                    o_next.phase = ttci_pkg::PH_IDLE;
                    unique case (i_byte)
                        ttci_pkg::CMD_ERASE:   o_cmd.op = ttci_pkg::ROP_ERASE;
                        ttci_pkg::CMD_CLEAR:   o_cmd.op = ttci_pkg::ROP_CLEAR;
                        ttci_pkg::CH_CARET: begin
                            o_cmd.op   = ttci_pkg::ROP_PUT;
                            o_next.col = w_col_inc;
                        end
                        ttci_pkg::CMD_RIGHT:   o_next.col = w_col_inc;
                        ttci_pkg::CMD_LEFT: begin
                            if (i_cur.col != '0) begin
                                o_next.col = i_cur.col - 1'b1;
                            end
                        end
                        ttci_pkg::CMD_UP: begin
                            if (i_cur.row != '0) begin
                                o_next.row = i_cur.row - 1'b1;
                            end
                        end
                        ttci_pkg::CMD_DOWN:    o_next.row = w_row_inc;
                        ttci_pkg::CMD_BOL:     o_next.col = '0;
                        ttci_pkg::CMD_HOME: begin
                            o_next.row = '0;
                            o_next.col = '0;
                        end
                        ttci_pkg::CMD_INS_ON:  o_next.ins = 1'b1;
                        ttci_pkg::CMD_INS_OFF: o_next.ins = 1'b0;
                        default: begin
                            if (w_is_digit) begin
                                o_next.row   = w_digit;
                                o_next.phase = ttci_pkg::PH_ROW;
                            end
                        end
                    endcase
                end else begin
                    // column digit; a bad one is dropped, the row stays set
                    if (w_is_digit) begin
                        o_next.col = w_digit;
                    end
                    o_next.phase = ttci_pkg::PH_IDLE;
                end
            end
            ttci_pkg::MODE_NEW: begin
                o_next.row   = '0;
                o_next.col   = '0;
                o_next.ins   = 1'b0;
                o_next.phase = ttci_pkg::PH_IDLE;
                o_cmd.op     = ttci_pkg::ROP_CLEAR;
            end
            default: begin
                // read and unused mode leave everything as is
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/text_terminal_control_interpreter.sv
// Top level of the terminal control sequence interpreter: input register,
// control decode, screen rows and result register.
// Depends on ttci_pkg, ttci_if, ttci_ctrl, ttci_row.
//
//  channel  | dir | handshake          | word
//  i_in     | in  | valid / ready      | mode, data_byte, read_row, read_col
//  o_out    | out | valid / ready      | cell_char, cursor_row, cursor_col,
//           |     |                    | insert_on, escape_phase
//
// One word per clock sustained while results are taken; each word passes the
// input register, then the state update and result register.
// The whole screen lives in flip-flops, so row shifts and full clears finish
// in the state update itself. Reset is synchronous and clears the screen to
// spaces in the same cycle. A stalled result only holds the input register
// when it is also full; one result waits while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_control_interpreter #(
    parameter int SCREEN_SIZE = ttci_pkg::SCREEN_SIZE_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ttci_in_if.sink      i_in,
    ttci_out_if.source   o_out
);

    localparam int IDX_W = $clog2(SCREEN_SIZE);
    localparam logic [ttci_pkg::POS_W-1:0] SIZE = ttci_pkg::POS_W'(SCREEN_SIZE);

    // input register
    logic                         r_s1_valid;
    logic [ttci_pkg::MODE_W-1:0]  r_s1_mode;
    logic [ttci_pkg::BYTE_W-1:0]  r_s1_byte;
    logic [ttci_pkg::POS_W-1:0]   r_s1_rrow;
    logic [ttci_pkg::POS_W-1:0]   r_s1_rcol;

    // terminal state and result register
    ttci_pkg::t_term_state        r_state;
    ttci_pkg::t_term_state        n_state;
    ttci_pkg::t_row_cmd           w_cmd;
    logic                         r_out_valid;
    logic [ttci_pkg::BYTE_W-1:0]  r_out_cell;
    ttci_pkg::t_term_state        r_out_state;

    logic                         w_s2_adv;
    logic                         w_in_acc;
    logic [ttci_pkg::BYTE_W-1:0]  w_cell;
    logic [SCREEN_SIZE-1:0][SCREEN_SIZE-1:0][ttci_pkg::BYTE_W-1:0] w_screen;

    assign w_s2_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s2_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mode <= i_in.mode;
            r_s1_byte <= i_in.data_byte;
            r_s1_rrow <= i_in.read_row;
            r_s1_rcol <= i_in.read_col;
        end
    end

    ttci_ctrl #(
        .SCREEN_SIZE (SCREEN_SIZE)
    ) u_ctrl (
        .i_mode (r_s1_mode),
        .i_byte (r_s1_byte),
        .i_cur  (r_state),
        .o_next (n_state),
        .o_cmd  (w_cmd)
    );

    for (genvar g = 0; g < SCREEN_SIZE; g++) begin : g_row
        ttci_row #(
            .SCREEN_SIZE (SCREEN_SIZE)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_s2_adv),
            .i_sel   (r_state.row == ttci_pkg::POS_W'(g)),
            .i_cmd   (w_cmd),
            .o_cells (w_screen[g])
        );
    end

    // cell read; out-of-range coordinates and non-read modes give zero
    always_comb begin
        w_cell = '0;
        if (r_s1_mode == ttci_pkg::MODE_READ && r_s1_rrow < SIZE && r_s1_rcol < SIZE) begin
            w_cell = w_screen[r_s1_rrow[IDX_W-1:0]][r_s1_rcol[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.row   <= '0;
            r_state.col   <= '0;
            r_state.ins   <= 1'b0;
            r_state.phase <= ttci_pkg::PH_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_s2_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_cell  <= w_cell;
            r_out_state <= n_state;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cell_char    = r_out_cell;
    assign o_out.cursor_row   = r_out_state.row;
    assign o_out.cursor_col   = r_out_state.col;
    assign o_out.insert_on    = r_out_state.ins;
    assign o_out.escape_phase = r_out_state.phase;

    // ---------------------------------------------------------------- checks

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_state.row < SIZE) && (r_state.col < SIZE))
        else $error("cursor outside screen");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_adv && r_s1_mode == ttci_pkg::MODE_READ) |=>
            $stable(r_state.row) && $stable(r_state.col) && $stable(r_state.phase)
            && $stable(r_state.ins))
        else $error("read mode changed terminal state");

    a_no_result_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_s1_valid) |=> !r_out_valid)
        else $error("result appeared with no word in flight");

    a_new_screen_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_adv && r_s1_mode == ttci_pkg::MODE_NEW) |=>
            (r_state.row == '0) && (r_state.col == '0) && !r_state.ins)
        else $error("new screen did not home the cursor");

endmodule

`default_nettype wire
